// ----- design/dteh_pkg.sv -----
// Shared types, codes, widths and saturating arithmetic for the dead-time histogrammer.
`default_nettype none

package dteh_pkg;

	// Fixed field widths.
	localparam int TIME_W = 40;
	localparam int SCALER_W = 32;
	localparam int INDEX_W = 16;
	localparam int COUNT_W = 32;
	localparam int SUM_W = 48;
	localparam int SHIFT_W = 5;
	localparam int CFG_ADDR_W = 2;

	// Operation codes carried in the input tuser.
	localparam logic [1:0] OP_EVENT = 2'd0;
	localparam logic [1:0] OP_READ_BIN = 2'd1;
	localparam logic [1:0] OP_READ_SLICE = 2'd2;

	// Codes for how an event gap was filled.
	localparam logic [1:0] FILL_NONE = 2'd0;
	localparam logic [1:0] FILL_BIN = 2'd1;
	localparam logic [1:0] FILL_UNDER = 2'd2;
	localparam logic [1:0] FILL_OVER = 2'd3;

	// Configuration register indexes.
	localparam logic [CFG_ADDR_W-1:0] CFG_DIFF_BIN_SHIFT = 2'd0;
	localparam logic [CFG_ADDR_W-1:0] CFG_SLICE_SHIFT = 2'd1;
	localparam logic [CFG_ADDR_W-1:0] CFG_MAX_DIFF_US = 2'd2;

	// Register reset values.
	localparam logic [SHIFT_W-1:0] DIFF_BIN_SHIFT_RST = 5'd2;
	localparam logic [SHIFT_W-1:0] SLICE_SHIFT_RST = 5'd23;
	localparam logic [TIME_W-1:0] MAX_DIFF_US_RST = 40'd100000000;

	// Decoded item travelling from the address stage to the memory stage.
	typedef struct packed {
		logic signed [TIME_W:0] time_diff;
		logic [1:0] filled;
		logic first_scalar;
		logic slice_dropped;
		logic hist_wr;
		logic slice_wr;
		logic bin_rd_ok;
		logic slice_rd_ok;
		logic [SCALER_W-1:0] dclk;
		logic [SCALER_W-1:0] dbusy;
	} ctl_t;

	// Increment that stops at the all-ones count.
	function automatic logic [COUNT_W-1:0] sat_inc32(input logic [COUNT_W-1:0] v);
		logic [COUNT_W-1:0] r;
		r = (v == '1) ? v : v + COUNT_W'(1);
		return r;
	endfunction

	// Add a scaler increment into a slice sum, stopping at the all-ones sum.
	function automatic logic [SUM_W-1:0] sat_add48(input logic [SUM_W-1:0] acc,
			input logic [SCALER_W-1:0] delta);
		logic [SUM_W:0] s;
		s = {1'b0, acc} + (SUM_W+1)'(delta);
		return s[SUM_W] ? '1 : s[SUM_W-1:0];
	endfunction

endpackage

`default_nettype wire

// ----- design/dead_time_event_histogrammer.sv -----
// Top level of the dead-time event histogrammer: handshakes, state, clearing and result register.
//
//  Port group  Dir  Contents
//  s_*         in   events and read requests
//  m_*         out  one result per request
//  cfg_*       in   register writes (0 bin shift, 1 slice shift, 2 gap limit)
//
// An item goes through the address stage, then the memory stage, where both memories do
// a read-modify-write on their single port; a new item enters once the address stage is
// empty. After reset a clearing pass over max(DIFF_BINS, SLICES) addresses zeroes both
// memories, and s_tready stays low until it ends. The result waits in an output register;
// until it is taken the memory stage holds and one more item may wait in the address stage.
`default_nettype none

module dead_time_event_histogrammer #(
	parameter int DIFF_BINS = 65536,
	parameter int SLICES = 1024
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic s_tvalid,
	output logic s_tready,
	// s_tdata: event_time[39:0], clock_count[71:40], busy_count[103:72], read_index[119:104]
	input wire logic [119:0] s_tdata,
	// s_tuser: operation[1:0], scalers_present[2]
	input wire logic [2:0] s_tuser,
	output logic m_tvalid,
	input wire logic m_tready,
	// m_tdata: time_diff[40:0], diff_filled[42:41], first_scalar[43], slice_dropped[44],
	//          bin_count[76:45], slice_clock_sum[124:77], slice_busy_sum[172:125]
	output logic [175:0] m_tdata,
	input wire logic cfg_we,
	input wire logic [dteh_pkg::CFG_ADDR_W-1:0] cfg_addr,
	input wire logic [dteh_pkg::TIME_W-1:0] cfg_wdata
);
	import dteh_pkg::*;

	localparam int BIN_W = $clog2(DIFF_BINS);
	localparam int SLICE_W = $clog2(SLICES);
	localparam int CLR_DEPTH = (DIFF_BINS > SLICES) ? DIFF_BINS : SLICES;
	localparam int CLR_W = $clog2(CLR_DEPTH);

	// Configuration registers.
	logic [SHIFT_W-1:0] diff_bin_shift_q;
	logic [SHIFT_W-1:0] slice_shift_q;
	logic [TIME_W-1:0] max_diff_us_q;

	// Event state.
	logic [TIME_W-1:0] previous_time_q;
	logic awaiting_first_q;
	logic [TIME_W-1:0] first_time_q;
	logic [SCALER_W-1:0] previous_clock_q;
	logic [SCALER_W-1:0] previous_busy_q;

	// Clearing pass.
	logic clr_busy_q;
	logic [CLR_W-1:0] clr_q;

	// Address stage.
	logic s1_valid_q;
	logic [1:0] op_s1;
	logic [TIME_W-1:0] time_s1;
	logic [SCALER_W-1:0] clock_s1;
	logic [SCALER_W-1:0] busy_s1;
	logic scalers_s1;
	logic [INDEX_W-1:0] index_s1;

	// Memory stage.
	logic s2_valid_q;
	ctl_t ctl_s1;
	ctl_t ctl_s2;
	logic [BIN_W-1:0] hist_addr;
	logic [SLICE_W-1:0] slice_addr;

	// Result register.
	logic m_tvalid_q;
	logic [175:0] m_tdata_q;

	logic accept;
	logic advance;
	logic s2_done;
	logic [COUNT_W-1:0] hist_data;
	logic [SUM_W-1:0] clock_sum;
	logic [SUM_W-1:0] busy_sum;
	logic [COUNT_W-1:0] bin_count;
	logic [SUM_W-1:0] slice_clock_sum;
	logic [SUM_W-1:0] slice_busy_sum;

	// Handshake and stage movement; an item leaves the address stage only into an empty
	// memory stage, so its arithmetic always sees the state left by the item before it.
	assign s_tready = !s1_valid_q && !clr_busy_q;
	assign accept = s_tvalid && s_tready;
	assign advance = s1_valid_q && !s2_valid_q;
	assign s2_done = s2_valid_q && (!m_tvalid_q || m_tready);

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			diff_bin_shift_q <= DIFF_BIN_SHIFT_RST;
			slice_shift_q <= SLICE_SHIFT_RST;
			max_diff_us_q <= MAX_DIFF_US_RST;
		end else if (cfg_we) begin
			case (cfg_addr)
				CFG_DIFF_BIN_SHIFT: diff_bin_shift_q <= cfg_wdata[SHIFT_W-1:0];
				CFG_SLICE_SHIFT: slice_shift_q <= cfg_wdata[SHIFT_W-1:0];
				CFG_MAX_DIFF_US: max_diff_us_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Clearing sweep over both memories after reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_q <= '0;
		end else if (clr_busy_q) begin
			if (clr_q == CLR_W'(CLR_DEPTH - 1)) begin
				clr_busy_q <= 1'b0;
			end else begin
				clr_q <= clr_q + CLR_W'(1);
			end
		end
	end

	// Stage valid flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
			s2_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				s1_valid_q <= 1'b1;
			end else if (advance) begin
				s1_valid_q <= 1'b0;
			end
			if (advance) begin
				s2_valid_q <= 1'b1;
			end else if (s2_done) begin
				s2_valid_q <= 1'b0;
			end
		end
	end

	// Input capture into the address stage.
	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1 <= s_tuser[1:0];
			scalers_s1 <= s_tuser[2];
			time_s1 <= s_tdata[39:0];
			clock_s1 <= s_tdata[71:40];
			busy_s1 <= s_tdata[103:72];
			index_s1 <= s_tdata[119:104];
		end
	end

	dteh_addr_calc #(
		.DIFF_BINS(DIFF_BINS),
		.SLICES(SLICES),
		.BIN_W(BIN_W),
		.SLICE_W(SLICE_W)
	) u_addr_calc (
		.op(op_s1),
		.event_time(time_s1),
		.clock_count(clock_s1),
		.busy_count(busy_s1),
		.scalers_present(scalers_s1),
		.read_index(index_s1),
		.previous_time(previous_time_q),
		.awaiting_first(awaiting_first_q),
		.first_time(first_time_q),
		.previous_clock(previous_clock_q),
		.previous_busy(previous_busy_q),
		.diff_bin_shift(diff_bin_shift_q),
		.slice_shift(slice_shift_q),
		.max_diff_us(max_diff_us_q),
		.ctl(ctl_s1),
		.hist_addr(hist_addr),
		.slice_addr(slice_addr)
	);

	// Event state follows each event as it enters the memory stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			previous_time_q <= '0;
			awaiting_first_q <= 1'b1;
			first_time_q <= '0;
			previous_clock_q <= '0;
			previous_busy_q <= '0;
		end else if (advance && (op_s1 == OP_EVENT)) begin
			previous_time_q <= time_s1;
			if (scalers_s1) begin
				if (awaiting_first_q) begin
					awaiting_first_q <= 1'b0;
					first_time_q <= time_s1;
				end
				previous_clock_q <= clock_s1;
				previous_busy_q <= busy_s1;
			end
		end
	end

	// Decoded control carried through the memory stage.
	always_ff @(posedge clk) begin
		if (advance) begin
			ctl_s2 <= ctl_s1;
		end
	end

	dteh_hist_bank #(
		.DIFF_BINS(DIFF_BINS),
		.BIN_W(BIN_W)
	) u_hist_bank (
		.clk(clk),
		.clr_en(clr_busy_q && (32'(clr_q) < 32'(DIFF_BINS))),
		.clr_addr(BIN_W'(clr_q)),
		.rd_en(advance),
		.rd_addr(hist_addr),
		.wr_en(s2_done && ctl_s2.hist_wr),
		.rd_data(hist_data)
	);

	dteh_slice_bank #(
		.SLICES(SLICES),
		.SLICE_W(SLICE_W)
	) u_slice_bank (
		.clk(clk),
		.clr_en(clr_busy_q && (32'(clr_q) < 32'(SLICES))),
		.clr_addr(SLICE_W'(clr_q)),
		.rd_en(advance),
		.rd_addr(slice_addr),
		.wr_en(s2_done && ctl_s2.slice_wr),
		.dclk(ctl_s2.dclk),
		.dbusy(ctl_s2.dbusy),
		.clock_sum(clock_sum),
		.busy_sum(busy_sum)
	);

	// Read results, zero when the index lies outside the store.
	assign bin_count = ctl_s2.bin_rd_ok ? hist_data : '0;
	assign slice_clock_sum = ctl_s2.slice_rd_ok ? clock_sum : '0;
	assign slice_busy_sum = ctl_s2.slice_rd_ok ? busy_sum : '0;

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (s2_done) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_done) begin
			m_tdata_q <= {3'b000, slice_busy_sum, slice_clock_sum, bin_count,
				ctl_s2.slice_dropped, ctl_s2.first_scalar, ctl_s2.filled, ctl_s2.time_diff};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata = m_tdata_q;

endmodule

`default_nettype wire

// ----- design/dteh_addr_calc.sv -----
// Address stage: gap and slice arithmetic, bin and slice addresses, result flags.
`default_nettype none

module dteh_addr_calc #(
	parameter int DIFF_BINS = 65536,
	parameter int SLICES = 1024,
	parameter int BIN_W = 16,
	parameter int SLICE_W = 10
) (
	input wire logic [1:0] op,
	input wire logic [dteh_pkg::TIME_W-1:0] event_time,
	input wire logic [dteh_pkg::SCALER_W-1:0] clock_count,
	input wire logic [dteh_pkg::SCALER_W-1:0] busy_count,
	input wire logic scalers_present,
	input wire logic [dteh_pkg::INDEX_W-1:0] read_index,
	input wire logic [dteh_pkg::TIME_W-1:0] previous_time,
	input wire logic awaiting_first,
	input wire logic [dteh_pkg::TIME_W-1:0] first_time,
	input wire logic [dteh_pkg::SCALER_W-1:0] previous_clock,
	input wire logic [dteh_pkg::SCALER_W-1:0] previous_busy,
	input wire logic [dteh_pkg::SHIFT_W-1:0] diff_bin_shift,
	input wire logic [dteh_pkg::SHIFT_W-1:0] slice_shift,
	input wire logic [dteh_pkg::TIME_W-1:0] max_diff_us,
	output dteh_pkg::ctl_t ctl,
	output logic [BIN_W-1:0] hist_addr,
	output logic [SLICE_W-1:0] slice_addr
);
	import dteh_pkg::*;

	logic [TIME_W:0] gap;
	logic gap_neg;
	logic gap_in_range;
	logic [TIME_W-1:0] bin;
	logic bin_ok;
	logic [TIME_W:0] since_first;
	logic since_neg;
	logic [TIME_W-1:0] slice;
	logic slice_ok;
	logic is_event;
	logic later_scaler;

	// Gap to the previous event and its histogram bin.
	assign gap = {1'b0, event_time} - {1'b0, previous_time};
	assign gap_neg = gap[TIME_W];
	assign gap_in_range = !gap_neg && (gap[TIME_W-1:0] < max_diff_us);
	assign bin = gap[TIME_W-1:0] >> diff_bin_shift;
	assign bin_ok = bin < TIME_W'(DIFF_BINS);

	// Time since the first scaler event and its slice.
	assign since_first = {1'b0, event_time} - {1'b0, first_time};
	assign since_neg = since_first[TIME_W];
	assign slice = since_first[TIME_W-1:0] >> slice_shift;
	assign slice_ok = slice < TIME_W'(SLICES);

	assign is_event = (op == OP_EVENT);
	assign later_scaler = is_event && scalers_present && !awaiting_first;

	// Decoded control for the memory stage.
	always_comb begin
		ctl = '0;
		if (is_event) begin
			ctl.time_diff = gap;
			if (gap_neg) begin
				ctl.filled = FILL_UNDER;
			end else if (gap_in_range) begin
				ctl.filled = bin_ok ? FILL_BIN : FILL_OVER;
			end else begin
				ctl.filled = FILL_NONE;
			end
			ctl.hist_wr = gap_in_range && bin_ok;
			ctl.first_scalar = scalers_present && awaiting_first;
			ctl.slice_dropped = later_scaler && (since_neg || !slice_ok);
			ctl.slice_wr = later_scaler && !since_neg && slice_ok;
		end
		ctl.bin_rd_ok = (op == OP_READ_BIN) && (32'(read_index) < 32'(DIFF_BINS));
		ctl.slice_rd_ok = (op == OP_READ_SLICE) && (32'(read_index) < 32'(SLICES));
		ctl.dclk = clock_count - previous_clock;
		ctl.dbusy = busy_count - previous_busy;
	end

	// Memory addresses: the read index for reads, the computed bin or slice for events.
	assign hist_addr = (op == OP_READ_BIN) ? BIN_W'({{BIN_W{1'b0}}, read_index})
		: bin[BIN_W-1:0];
	assign slice_addr = (op == OP_READ_SLICE) ? SLICE_W'({{SLICE_W{1'b0}}, read_index})
		: slice[SLICE_W-1:0];

endmodule

`default_nettype wire

// ----- design/dteh_hist_bank.sv -----
// Difference histogram memory with saturating read-modify-write and clearing port.
`default_nettype none

module dteh_hist_bank #(
	parameter int DIFF_BINS = 65536,
	parameter int BIN_W = 16
) (
	input wire logic clk,
	input wire logic clr_en,
	input wire logic [BIN_W-1:0] clr_addr,
	input wire logic rd_en,
	input wire logic [BIN_W-1:0] rd_addr,
	input wire logic wr_en,
	output logic [dteh_pkg::COUNT_W-1:0] rd_data
);
	import dteh_pkg::*;

	logic [COUNT_W-1:0] mem_q [DIFF_BINS];
	logic [COUNT_W-1:0] rd_data_q;
	logic [BIN_W-1:0] addr_q;

	// Registered read; the address is kept for the write-back.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
			addr_q <= rd_addr;
		end
	end

	// Single write port: clearing pass after reset, otherwise the incremented count.
	always_ff @(posedge clk) begin
		if (clr_en) begin
			mem_q[clr_addr] <= '0;
		end else if (wr_en) begin
			mem_q[addr_q] <= sat_inc32(rd_data_q);
		end
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

// ----- design/dteh_slice_bank.sv -----
// Slice memory holding clock and busy sums side by side, with saturating accumulate.
`default_nettype none

module dteh_slice_bank #(
	parameter int SLICES = 1024,
	parameter int SLICE_W = 10
) (
	input wire logic clk,
	input wire logic clr_en,
	input wire logic [SLICE_W-1:0] clr_addr,
	input wire logic rd_en,
	input wire logic [SLICE_W-1:0] rd_addr,
	input wire logic wr_en,
	input wire logic [dteh_pkg::SCALER_W-1:0] dclk,
	input wire logic [dteh_pkg::SCALER_W-1:0] dbusy,
	output logic [dteh_pkg::SUM_W-1:0] clock_sum,
	output logic [dteh_pkg::SUM_W-1:0] busy_sum
);
	import dteh_pkg::*;

	// Each entry holds the busy sum in the upper half and the clock sum in the lower.
	logic [2*SUM_W-1:0] mem_q [SLICES];
	logic [2*SUM_W-1:0] rd_data_q;
	logic [SLICE_W-1:0] addr_q;

	// Registered read; the address is kept for the write-back.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
			addr_q <= rd_addr;
		end
	end

	// Single write port: clearing pass after reset, otherwise the accumulated sums.
	always_ff @(posedge clk) begin
		if (clr_en) begin
			mem_q[clr_addr] <= '0;
		end else if (wr_en) begin
			mem_q[addr_q] <= {sat_add48(rd_data_q[2*SUM_W-1:SUM_W], dbusy),
				sat_add48(rd_data_q[SUM_W-1:0], dclk)};
		end
	end

	assign clock_sum = rd_data_q[SUM_W-1:0];
	assign busy_sum = rd_data_q[2*SUM_W-1:SUM_W];

endmodule

`default_nettype wire

// ----- sim/tb_top.sv -----
// Self-checking testbench for the dead-time event histogrammer: directed and random traffic.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import dteh_pkg::*;

	localparam int HIST_BINS = 65536;
	localparam int SLICE_COUNT = 1024;
	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam logic [TIME_W-1:0] FIRST_SCALER_TIME = 40'h00_0010_0000;
	localparam logic [63:0] TIME_MASK = 64'hFF_FFFF_FFFF;
	localparam int STEADY_EVENTS = 40;
	localparam int CYCLE_LIMIT = 2000000;

	// Receiver stall patterns.
	typedef enum logic [1:0] {RX_OPEN, RX_CHOPPY, RX_SLOW} rx_mode_t;

	// One request as it travels on the slave side.
	typedef struct packed {
		logic [1:0] op;
		logic [TIME_W-1:0] ev_time;
		logic [SCALER_W-1:0] clk_cnt;
		logic [SCALER_W-1:0] busy_cnt;
		logic scalers;
		logic [INDEX_W-1:0] idx;
	} request_t;

	// One result, laid out exactly as m_tdata from the top bit down.
	typedef struct packed {
		logic [2:0] pad;
		logic [SUM_W-1:0] busy_sum;
		logic [SUM_W-1:0] clock_sum;
		logic [COUNT_W-1:0] bin_count;
		logic slice_dropped;
		logic first_scalar;
		logic [1:0] filled;
		logic [TIME_W:0] time_diff;
	} result_t;

	logic clk;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [119:0] s_tdata = '0;
	logic [2:0] s_tuser = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [175:0] m_tdata;
	logic cfg_we = 1'b0;
	logic [CFG_ADDR_W-1:0] cfg_addr = '0;
	logic [TIME_W-1:0] cfg_wdata = '0;

	// Predicted block state and register copies.
	bit [COUNT_W-1:0] gap_hist [HIST_BINS];
	bit [COUNT_W-1:0] gap_under;
	bit [COUNT_W-1:0] gap_over;
	bit [SUM_W-1:0] clock_slices [SLICE_COUNT];
	bit [SUM_W-1:0] busy_slices [SLICE_COUNT];
	bit [TIME_W-1:0] last_time;
	bit [TIME_W-1:0] ref_time;
	bit awaiting_ref = 1'b1;
	bit [SCALER_W-1:0] ref_clk;
	bit [SCALER_W-1:0] ref_busy;
	bit [SHIFT_W-1:0] bin_shift = DIFF_BIN_SHIFT_RST;
	bit [SHIFT_W-1:0] slice_shift_cfg = SLICE_SHIFT_RST;
	bit [TIME_W-1:0] gap_limit = MAX_DIFF_US_RST;

	// Pending requests and results still owed by the block.
	request_t queued_requests [$];
	result_t due_results [$];

	// Last values handed to the request queue, used to shape the next ones.
	logic [TIME_W-1:0] gen_time = '0;
	logic [SCALER_W-1:0] gen_clk = '0;
	logic [SCALER_W-1:0] gen_busy = '0;
	int gen_slice = 0;

	request_t driven_req;
	int gap_left;
	int burst_left;
	rx_mode_t rx_mode;
	int rx_left;
	bit steady_run;
	int mismatch_count;
	int result_index;
	int cycle_count;

	dead_time_event_histogrammer #(
		.DIFF_BINS(HIST_BINS),
		.SLICES(SLICE_COUNT)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_we(cfg_we),
		.cfg_addr(cfg_addr),
		.cfg_wdata(cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Counter increment that sticks at all ones.
	function automatic bit [COUNT_W-1:0] count_up(input bit [COUNT_W-1:0] v);
		return (v == '1) ? v : v + COUNT_W'(1);
	endfunction

	// Slice accumulation that clamps at the largest sum.
	function automatic bit [SUM_W-1:0] sum_clamped(input bit [SUM_W-1:0] acc,
			input bit [SCALER_W-1:0] inc);
		bit [SUM_W:0] s;
		s = {1'b0, acc} + {17'd0, inc};
		return s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
	endfunction

	// Advance the predicted state by one request and return the result it produces.
	function automatic result_t apply_request(input request_t r);
		result_t res;
		bit [TIME_W-1:0] d;
		bit [TIME_W-1:0] bin;
		bit [TIME_W-1:0] slice;
		bit [SCALER_W-1:0] dclk;
		bit [SCALER_W-1:0] dbusy;
		res = '0;
		case (r.op)
			OP_EVENT: begin
				res.time_diff = {1'b0, r.ev_time} - {1'b0, last_time};
				if (r.ev_time < last_time) begin
					gap_under = count_up(gap_under);
					res.filled = FILL_UNDER;
				end else begin
					d = r.ev_time - last_time;
					if (d < gap_limit) begin
						bin = d >> bin_shift;
						if (bin < HIST_BINS) begin
							gap_hist[bin[15:0]] = count_up(gap_hist[bin[15:0]]);
							res.filled = FILL_BIN;
						end else begin
							gap_over = count_up(gap_over);
							res.filled = FILL_OVER;
						end
					end
				end
				last_time = r.ev_time;
				if (r.scalers) begin
					if (awaiting_ref) begin
						awaiting_ref = 1'b0;
						ref_time = r.ev_time;
						res.first_scalar = 1'b1;
					end else begin
						dclk = r.clk_cnt - ref_clk;
						dbusy = r.busy_cnt - ref_busy;
						if (r.ev_time < ref_time) begin
							res.slice_dropped = 1'b1;
						end else begin
							slice = (r.ev_time - ref_time) >> slice_shift_cfg;
							if (slice < SLICE_COUNT) begin
								clock_slices[slice[9:0]] = sum_clamped(clock_slices[slice[9:0]], dclk);
								busy_slices[slice[9:0]] = sum_clamped(busy_slices[slice[9:0]], dbusy);
							end else begin
								res.slice_dropped = 1'b1;
							end
						end
					end
					ref_clk = r.clk_cnt;
					ref_busy = r.busy_cnt;
				end
			end
			OP_READ_BIN: begin
				res.bin_count = gap_hist[r.idx];
			end
			OP_READ_SLICE: begin
				if (r.idx < SLICE_COUNT) begin
					res.clock_sum = clock_slices[r.idx[9:0]];
					res.busy_sum = busy_slices[r.idx[9:0]];
				end
			end
			default: begin
			end
		endcase
		return res;
	endfunction

	task automatic note_mismatch(input string field, input logic [63:0] got,
			input logic [63:0] want);
		$display("mismatch on result %0d, %s: got %h, expected %h", result_index, field, got,
			want);
		mismatch_count++;
	endtask

	// Compare one result field by field with the oldest prediction.
	task automatic check_result(input result_t got);
		result_t want;
		result_index++;
		if (due_results.size() == 0) begin
			note_mismatch("result with nothing outstanding", got[63:0], 64'd0);
		end else begin
			want = due_results.pop_front();
			if (got.time_diff !== want.time_diff)
				note_mismatch("time_diff", 64'(got.time_diff), 64'(want.time_diff));
			if (got.filled !== want.filled)
				note_mismatch("diff_filled", 64'(got.filled), 64'(want.filled));
			if (got.first_scalar !== want.first_scalar)
				note_mismatch("first_scalar", 64'(got.first_scalar), 64'(want.first_scalar));
			if (got.slice_dropped !== want.slice_dropped)
				note_mismatch("slice_dropped", 64'(got.slice_dropped),
					64'(want.slice_dropped));
			if (got.bin_count !== want.bin_count)
				note_mismatch("bin_count", 64'(got.bin_count), 64'(want.bin_count));
			if (got.clock_sum !== want.clock_sum)
				note_mismatch("slice_clock_sum", 64'(got.clock_sum), 64'(want.clock_sum));
			if (got.busy_sum !== want.busy_sum)
				note_mismatch("slice_busy_sum", 64'(got.busy_sum), 64'(want.busy_sum));
			if (got.pad !== want.pad)
				note_mismatch("tdata padding", 64'(got.pad), 64'(want.pad));
		end
	endtask

	// Queue a request and remember where the generated stream stands.
	task automatic queue_request(input request_t r);
		queued_requests.push_back(r);
		if (r.op == OP_EVENT) begin
			gen_time = r.ev_time;
			if (r.scalers) begin
				gen_clk = r.clk_cnt;
				gen_busy = r.busy_cnt;
				if (r.ev_time >= FIRST_SCALER_TIME &&
						((r.ev_time - FIRST_SCALER_TIME) >> slice_shift_cfg) < SLICE_COUNT)
					gen_slice = int'((r.ev_time - FIRST_SCALER_TIME) >> slice_shift_cfg);
			end
		end
	endtask

	task automatic queue_event(input logic [63:0] t, input logic [SCALER_W-1:0] c,
			input logic [SCALER_W-1:0] b, input bit sc);
		request_t r;
		r = '0;
		r.op = OP_EVENT;
		r.ev_time = t[TIME_W-1:0];
		r.clk_cnt = c;
		r.busy_cnt = b;
		r.scalers = sc;
		queue_request(r);
	endtask

	task automatic queue_read(input logic [1:0] op, input logic [INDEX_W-1:0] idx);
		request_t r;
		r = '0;
		r.op = op;
		r.idx = idx;
		queue_request(r);
	endtask

	// Write all three registers while the block is idle, then update the copies.
	task automatic program_registers(input int ds, input int ss, input logic [TIME_W-1:0] md);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_addr <= CFG_DIFF_BIN_SHIFT;
		cfg_wdata <= TIME_W'(ds);
		@(posedge clk);
		cfg_addr <= CFG_SLICE_SHIFT;
		cfg_wdata <= TIME_W'(ss);
		@(posedge clk);
		cfg_addr <= CFG_MAX_DIFF_US;
		cfg_wdata <= md;
		@(posedge clk);
		cfg_we <= 1'b0;
		bin_shift = SHIFT_W'(ds);
		slice_shift_cfg = SHIFT_W'(ss);
		gap_limit = md;
		@(negedge clk);
	endtask

	task automatic wait_idle();
		while (queued_requests.size() != 0 || s_tvalid || due_results.size() != 0)
			@(negedge clk);
	endtask

	// Mostly well-formed event streams around the first scaler time, plus reads and noise.
	task automatic queue_random_items(input int n);
		logic [63:0] d;
		logic [63:0] t;
		logic [SCALER_W-1:0] c;
		logic [SCALER_W-1:0] b;
		int pick;
		request_t r;
		repeat (n) begin
			pick = $urandom_range(0, 99);
			if (pick < 45) begin
				d = (64'($urandom_range(0, 300)) << bin_shift) |
					(64'($urandom) & ((64'd1 << bin_shift) - 1));
				c = gen_clk + $urandom_range(0, 200000);
				b = gen_busy + $urandom_range(0, 200000);
				if ($urandom_range(0, 9) == 0) begin
					c = $urandom;
					b = $urandom;
				end
				queue_event(64'(gen_time) + d, c, b, $urandom_range(0, 9) < 7);
			end else if (pick < 55) begin
				// Gaps right around the limit or the top histogram bin.
				if ($urandom_range(0, 1) == 0)
					d = 64'(gap_limit) + $urandom_range(0, 2) - 1;
				else
					d = (64'd65535 + $urandom_range(0, 1)) << bin_shift;
				queue_event(64'(gen_time) + d, gen_clk + $urandom_range(0, 1000),
					gen_busy + $urandom_range(0, 1000), $urandom_range(0, 1) == 1);
			end else if (pick < 62) begin
				// Jump back near the first scaler event, sometimes before it or past the store.
				if ($urandom_range(0, 3) == 0)
					t = 64'(FIRST_SCALER_TIME) - $urandom_range(1, 5000);
				else
					t = 64'(FIRST_SCALER_TIME) +
						(64'($urandom_range(0, SLICE_COUNT + 8)) << slice_shift_cfg) +
						(64'($urandom) & ((64'd1 << slice_shift_cfg) - 1));
				queue_event(t, gen_clk + $urandom_range(0, 1 << 20),
					gen_busy + $urandom_range(0, 1 << 16), 1'b1);
			end else if (pick < 77) begin
				if ($urandom_range(0, 3) == 0)
					queue_read(OP_READ_BIN, INDEX_W'($urandom));
				else
					queue_read(OP_READ_BIN, INDEX_W'($urandom_range(0, 300)));
			end else if (pick < 92) begin
				case ($urandom_range(0, 3))
					0: queue_read(OP_READ_SLICE, INDEX_W'($urandom));
					1: queue_read(OP_READ_SLICE, INDEX_W'($urandom_range(0, SLICE_COUNT + 8)));
					default: queue_read(OP_READ_SLICE, INDEX_W'(gen_slice));
				endcase
			end else begin
				r.op = 2'($urandom);
				r.ev_time = {8'($urandom), 32'($urandom)};
				r.clk_cnt = $urandom;
				r.busy_cnt = $urandom;
				r.scalers = 1'($urandom);
				r.idx = INDEX_W'($urandom);
				queue_request(r);
			end
		end
	endtask

	task automatic run_phase(input int ds, input int ss, input logic [TIME_W-1:0] md,
			input int n);
		program_registers(ds, ss, md);
		queue_random_items(n);
		wait_idle();
	endtask

	// Sender: pops pending requests and presents them in bursts with gaps, unless steady_run.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= '0;
			gap_left = 0;
			burst_left = 0;
		end else begin
			// Predict as each transaction is accepted, in acceptance order.
			if (s_tvalid && s_tready)
				due_results.push_back(apply_request(driven_req));
			if (!s_tvalid || s_tready) begin
				if (gap_left != 0) begin
					gap_left--;
					s_tvalid <= 1'b0;
				end else if (queued_requests.size() != 0) begin
					driven_req = queued_requests.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= {driven_req.idx, driven_req.busy_cnt, driven_req.clk_cnt,
						driven_req.ev_time};
					s_tuser <= {driven_req.scalers, driven_req.op};
					if (!steady_run) begin
						if (burst_left == 0)
							burst_left = ($urandom_range(0, 4) == 0) ?
								$urandom_range(20, 60) : $urandom_range(1, 8);
						burst_left--;
						if (burst_left == 0)
							gap_left = ($urandom_range(0, 3) == 0) ?
								$urandom_range(5, 15) : $urandom_range(1, 4);
					end
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Receiver: checks each transaction and stalls in changing patterns, unless steady_run.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			rx_mode = RX_OPEN;
			rx_left = 0;
		end else begin
			if (m_tvalid && m_tready)
				check_result(m_tdata);
			if (rx_left == 0) begin
				rx_mode = rx_mode_t'($urandom_range(0, 2));
				rx_left = $urandom_range(16, 160);
			end
			rx_left--;
			if (steady_run) begin
				m_tready <= 1'b1;
			end else begin
				case (rx_mode)
					RX_OPEN: m_tready <= 1'b1;
					RX_CHOPPY: m_tready <= ($urandom_range(0, 3) != 0);
					default: m_tready <= ($urandom_range(0, 4) == 0);
				endcase
			end
		end
	end

	// Watchdog against a hung block.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// Stimulus sequence.
	initial begin
		request_t r;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		program_registers(int'(DIFF_BIN_SHIFT_RST), int'(SLICE_SHIFT_RST), MAX_DIFF_US_RST);

		// Reads of a cleared block and the unused operation code.
		queue_read(OP_READ_BIN, '0);
		queue_read(OP_READ_SLICE, '0);
		queue_read(OP_READ_SLICE, '1);
		r.op = OP_UNUSED;
		r.ev_time = '1;
		r.clk_cnt = '1;
		r.busy_cnt = '1;
		r.scalers = 1'b1;
		r.idx = '1;
		queue_request(r);
		// Zero gap, then the first scaler event, which captures references instead of filling a slice.
		queue_event(64'd0, '0, '0, 1'b0);
		queue_event(64'(FIRST_SCALER_TIME), 32'hFFFF_FFF0, 32'h10, 1'b1);
		// Scaler increment that wraps, then a slice past the store.
		queue_event(64'(FIRST_SCALER_TIME) + 100, 32'h10, 32'h20, 1'b1);
		queue_event(64'(FIRST_SCALER_TIME) + (64'(SLICE_COUNT) << SLICE_SHIFT_RST), 32'h1000,
			32'h30, 1'b1);
		// Earlier than the first scaler event: underflow and a dropped slice.
		queue_event(64'(FIRST_SCALER_TIME) - 1, 32'h2000, 32'h40, 1'b1);
		// Gap just under the limit, then exactly at it.
		queue_event(64'(gen_time) + 64'(MAX_DIFF_US_RST) - 64'd1, '0, '0, 1'b0);
		queue_event(64'(gen_time) + 64'(MAX_DIFF_US_RST), '0, '0, 1'b0);
		// Largest timestamp and scaler values.
		queue_event(TIME_MASK, '1, '1, 1'b1);
		queue_event(TIME_MASK, '0, '0, 1'b0);
		// Top in-range bin, then the first overflowing one.
		queue_event(64'(FIRST_SCALER_TIME) + 200, 32'h3000, 32'h50, 1'b1);
		queue_event(64'(gen_time) + (64'd65536 << DIFF_BIN_SHIFT_RST) - 1, 32'h3100, 32'h60,
			1'b1);
		queue_event(64'(gen_time) + (64'd65536 << DIFF_BIN_SHIFT_RST), '0, '0, 1'b0);
		queue_read(OP_READ_BIN, '0);
		queue_read(OP_READ_BIN, 16'd25);
		queue_read(OP_READ_BIN, '1);
		queue_read(OP_READ_SLICE, '0);
		queue_read(OP_READ_SLICE, INDEX_W'(SLICE_COUNT - 1));
		wait_idle();

		// Random traffic under several register settings, extremes included.
		run_phase(0, 10, 40'd1, 120);
		run_phase(16, 30, '1, 120);
		run_phase(31, 31, '0, 120);
		run_phase(3, 14, 40'd50000, 120);
		run_phase($urandom_range(0, 16), $urandom_range(10, 30),
			{8'($urandom), 32'($urandom)}, 120);

		// Feed one slice with maximal scaler increments, back to back.
		program_registers(4, 31, MAX_DIFF_US_RST);
		steady_run = 1'b1;
		repeat (STEADY_EVENTS)
			queue_event(64'(FIRST_SCALER_TIME) + $urandom_range(0, 1 << 20),
				gen_clk - SCALER_W'(1), gen_busy - SCALER_W'(1), 1'b1);
		queue_read(OP_READ_SLICE, '0);
		queue_read(OP_READ_BIN, '0);
		wait_idle();
		steady_run = 1'b0;

		// Let any stray result show up before the verdict.
		repeat (20) @(posedge clk);
		if (mismatch_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
